// ===== sv/kcrs_pkg.sv =====
// Shared constants for the key-color region scan block.
// No dependencies; used by key_color_region_scan.
package kcrs_pkg;

  // Default map limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_KEY_COLOR  = 2'd2;

  // Configuration reset values
  localparam logic [8:0]  MAP_WIDTH_RST  = 9'd256;
  localparam logic [8:0]  MAP_HEIGHT_RST = 9'd256;
  localparam logic [23:0] KEY_COLOR_RST  = 24'hFF00FF;

  // Request commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Coordinate reported when nothing is hit (-1 in 9 bits)
  localparam logic [8:0] NO_HIT_COORD = 9'h1FF;

endpackage

// ===== sv/kcrs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instanced by key_color_region_scan.
module kcrs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/key_color_region_scan.sv =====
// Key-color collision map with first-hit rectangle scan (top level).
// Depends on kcrs_pkg and kcrs_ram.
//
// One solid flag per pixel lives in a MAX_WIDTH x MAX_HEIGHT single-bit RAM.
// A load request writes the flag of one pixel (set when its RGB equals
// key_color); indexes beyond the RAM are dropped. A query request clips its
// rectangle to the map in use and reads the window one flag per cycle, row by
// row, left to right, stopping at the first solid flag; when nothing is hit it
// reads the whole clipped window, and an empty window skips the scan. The
// single read port of the flag RAM sets the scan rate. Flags come up undefined
// after reset: load every pixel a query can touch before querying.
// Configuration must only be written while idle.
module key_color_region_scan #(
  parameter int MAX_WIDTH  = kcrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = kcrs_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  // requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [15:0]        in_pixel_index,
  input  logic [7:0]         in_pixel_red,
  input  logic [7:0]         in_pixel_green,
  input  logic [7:0]         in_pixel_blue,
  input  logic signed [15:0] in_rect_left,
  input  logic signed [15:0] in_rect_top,
  input  logic signed [15:0] in_rect_right,
  input  logic signed [15:0] in_rect_bottom,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic signed [8:0]  out_hit_x,
  output logic signed [8:0]  out_hit_y
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [8:0]    map_w_r, map_h_r;
  logic [23:0]   key_r;
  logic [WW-1:0] w_r, w_nxt;
  logic [XW-1:0] sx_r, sx_nxt, ex_r, ex_nxt;
  logic [YW-1:0] sy_r, sy_nxt, ey_r, ey_nxt;
  logic [XW-1:0] rd_x_r, rd_x_nxt, chk_x_r, chk_x_nxt;
  logic [YW-1:0] rd_y_r, rd_y_nxt, chk_y_r, chk_y_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic          issue_done_r, issue_done_nxt;
  logic          chk_valid_r, chk_valid_nxt;
  logic          chk_last_r, chk_last_nxt;
  logic          fin_hit_r, fin_hit_nxt;
  logic [8:0]    fin_x_r, fin_x_nxt, fin_y_r, fin_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [8:0]    out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  logic              accept;
  logic [WW-1:0]     w_clamp;
  logic [HW-1:0]     h_clamp;
  logic signed [17:0] l18, t18, r18, b18, wlim, hlim;
  logic signed [17:0] sx18, sy18, ex18, ey18;
  logic              empty;
  logic [YW+WW-1:0]  prod;
  logic [AW-1:0]     rd_addr;
  logic              issue, row_end, last, fin_hit, fin_miss;
  logic [31:0]       idx32, cx32, cy32;
  logic              ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]     ram_waddr;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_hit_x = out_x_r;
  assign out_hit_y = out_y_r;

  // map size in use: zero counts as one, large values saturate
  always_comb begin
    if (map_w_r == '0) begin
      w_clamp = WW'(1);
    end else if (32'(map_w_r) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(map_w_r);
    end
    if (map_h_r == '0) begin
      h_clamp = HW'(1);
    end else if (32'(map_h_r) > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(map_h_r);
    end
  end

  // rectangle clipping
  always_comb begin
    l18  = 18'(in_rect_left);
    t18  = 18'(in_rect_top);
    r18  = 18'(in_rect_right);
    b18  = 18'(in_rect_bottom);
    wlim = signed'({{(18-WW){1'b0}}, w_clamp}) - 18'sd1;
    hlim = signed'({{(18-HW){1'b0}}, h_clamp}) - 18'sd1;
    sx18 = (l18 < 18'sd0) ? 18'sd0 : l18;
    sy18 = (t18 < 18'sd0) ? 18'sd0 : t18;
    ex18 = (r18 > wlim) ? wlim : r18;
    ey18 = (b18 > hlim) ? hlim : b18;
    empty = (sx18 > ex18) || (sy18 > ey18);
  end

  // load path
  assign idx32     = 32'(in_pixel_index);
  assign ram_waddr = idx32[AW-1:0];
  assign ram_wdata = ({in_pixel_red, in_pixel_green, in_pixel_blue} == key_r);
  assign ram_we    = accept && (in_cmd == kcrs_pkg::CMD_LOAD) && (idx32 < 32'(DEPTH));

  // scan datapath
  assign prod     = sy_r * w_r;
  assign rd_addr  = base_r + AW'(rd_x_r);
  assign row_end  = (rd_x_r == ex_r);
  assign last     = row_end && (rd_y_r == ey_r);
  assign fin_hit  = chk_valid_r && ram_rdata;
  assign fin_miss = chk_valid_r && chk_last_r && !ram_rdata;
  assign issue    = (state_r == S_SCAN) && !issue_done_r && !fin_hit && !fin_miss;
  assign cx32     = 32'(chk_x_r);
  assign cy32     = 32'(chk_y_r);

  kcrs_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    sx_nxt         = sx_r;
    ex_nxt         = ex_r;
    sy_nxt         = sy_r;
    ey_nxt         = ey_r;
    rd_x_nxt       = rd_x_r;
    rd_y_nxt       = rd_y_r;
    base_nxt       = base_r;
    issue_done_nxt = issue_done_r;
    chk_valid_nxt  = issue;
    chk_last_nxt   = chk_last_r;
    chk_x_nxt      = chk_x_r;
    chk_y_nxt      = chk_y_r;
    fin_hit_nxt    = fin_hit_r;
    fin_x_nxt      = fin_x_r;
    fin_y_nxt      = fin_y_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hit_nxt    = out_hit_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == kcrs_pkg::CMD_QUERY)) begin
          w_nxt  = w_clamp;
          sx_nxt = sx18[XW-1:0];
          ex_nxt = ex18[XW-1:0];
          sy_nxt = sy18[YW-1:0];
          ey_nxt = ey18[YW-1:0];
          if (empty) begin
            fin_hit_nxt = 1'b0;
            fin_x_nxt   = kcrs_pkg::NO_HIT_COORD;
            fin_y_nxt   = kcrs_pkg::NO_HIT_COORD;
            state_nxt   = S_FIN;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        base_nxt       = prod[AW-1:0];
        rd_x_nxt       = sx_r;
        rd_y_nxt       = sy_r;
        issue_done_nxt = 1'b0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        // check the flag read last cycle
        if (fin_hit) begin
          fin_hit_nxt = 1'b1;
          fin_x_nxt   = cx32[8:0];
          fin_y_nxt   = cy32[8:0];
          state_nxt   = S_FIN;
        end else if (fin_miss) begin
          fin_hit_nxt = 1'b0;
          fin_x_nxt   = kcrs_pkg::NO_HIT_COORD;
          fin_y_nxt   = kcrs_pkg::NO_HIT_COORD;
          state_nxt   = S_FIN;
        end
        // step the read pointer
        if (issue) begin
          chk_x_nxt      = rd_x_r;
          chk_y_nxt      = rd_y_r;
          chk_last_nxt   = last;
          issue_done_nxt = last;
          if (row_end) begin
            rd_x_nxt = sx_r;
            rd_y_nxt = rd_y_r + YW'(1);
            base_nxt = base_r + AW'(w_r);
          end else begin
            rd_x_nxt = rd_x_r + XW'(1);
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = fin_hit_r;
          out_x_nxt     = fin_x_r;
          out_y_nxt     = fin_y_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      map_w_r     <= kcrs_pkg::MAP_WIDTH_RST;
      map_h_r     <= kcrs_pkg::MAP_HEIGHT_RST;
      key_r       <= kcrs_pkg::KEY_COLOR_RST;
    end else begin
      state_r     <= state_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          kcrs_pkg::CFG_MAP_WIDTH:  map_w_r <= cfg_wdata[8:0];
          kcrs_pkg::CFG_MAP_HEIGHT: map_h_r <= cfg_wdata[8:0];
          kcrs_pkg::CFG_KEY_COLOR:  key_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    sx_r         <= sx_nxt;
    ex_r         <= ex_nxt;
    sy_r         <= sy_nxt;
    ey_r         <= ey_nxt;
    rd_x_r       <= rd_x_nxt;
    rd_y_r       <= rd_y_nxt;
    base_r       <= base_nxt;
    issue_done_r <= issue_done_nxt;
    chk_last_r   <= chk_last_nxt;
    chk_x_r      <= chk_x_nxt;
    chk_y_r      <= chk_y_nxt;
    fin_hit_r    <= fin_hit_nxt;
    fin_x_r      <= fin_x_nxt;
    fin_y_r      <= fin_y_nxt;
    out_hit_r    <= out_hit_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
  end

`ifndef ASSERT_OFF
  // flag RAM is written only between queries
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("flag write outside idle");

  // a read in flight belongs to an active scan
  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_valid_r |-> state_r == S_SCAN)
    else $error("flag check outside scan");

  // a finished query always lands in the output register
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && (!out_valid_r || out_ready)) |=> out_valid_r && state_r == S_IDLE)
    else $error("query result lost");

  // a miss reports (-1,-1)
  a_miss_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |->
      (out_x_r == kcrs_pkg::NO_HIT_COORD && out_y_r == kcrs_pkg::NO_HIT_COORD))
    else $error("miss with coordinates");
`endif

endmodule
